/* src/air_comfort_index_score_unit_defines.svh */
// Assertion macros for the air comfort index score unit.
// Included by the RTL files that carry assertions; needs clk and rst_n in scope.
`ifndef AIR_COMFORT_INDEX_SCORE_UNIT_DEFINES_SVH
`define AIR_COMFORT_INDEX_SCORE_UNIT_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define ACIS_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Condition that must never be seen outside reset.
`define ACIS_ASSERT_NEVER(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error(msg);

`endif

/* src/acis_pkg.sv */
// Shared types, constants and sub-score functions of the comfort index unit.
// No dependencies; used by every module of the block.
`default_nettype none

package acis_pkg;

    localparam int SCORE_W  = 14;
    localparam int WEIGHT_W = 7;
    localparam int PROD_W   = SCORE_W + WEIGHT_W;
    localparam int COMP_W   = 22;
    localparam int CALC_W   = 21;

    typedef logic [SCORE_W-1:0]  score_t;
    typedef logic [WEIGHT_W-1:0] weight_t;
    typedef logic [PROD_W-1:0]   prod_t;
    typedef logic [COMP_W-1:0]   comp_t;
    typedef logic [2:0]          label_t;
    typedef logic [1:0]          reg_idx_t;
    typedef logic signed [CALC_W-1:0] calc_t;

    typedef struct packed {
        score_t co2;
        score_t temp;
        score_t hum;
    } score_set_t;

    typedef struct packed {
        weight_t co2;
        weight_t temp;
        weight_t hum;
    } weight_set_t;

    typedef struct packed {
        prod_t co2;
        prod_t temp;
        prod_t hum;
    } prod_set_t;

    // Register indexes
    localparam reg_idx_t REG_CO2_WEIGHT  = 2'd0;
    localparam reg_idx_t REG_TEMP_WEIGHT = 2'd1;
    localparam reg_idx_t REG_HUM_WEIGHT  = 2'd2;

    localparam weight_t CO2_WEIGHT_RST  = 7'd40;
    localparam weight_t TEMP_WEIGHT_RST = 7'd35;
    localparam weight_t HUM_WEIGHT_RST  = 7'd25;

    // Label classes
    localparam label_t LABEL_EXCELLENT = 3'd0;
    localparam label_t LABEL_GOOD      = 3'd1;
    localparam label_t LABEL_AVERAGE   = 3'd2;
    localparam label_t LABEL_POOR      = 3'd3;
    localparam label_t LABEL_CRITICAL  = 3'd4;

    localparam comp_t THR_EXCELLENT = 22'd800000;
    localparam comp_t THR_GOOD      = 22'd600000;
    localparam comp_t THR_AVERAGE   = 22'd400000;
    localparam comp_t THR_POOR      = 22'd200000;

    localparam score_t SCORE_MAX = 14'd10000;

    function automatic score_t clamp_score(input calc_t r);
        score_t s;
        s = (r < 21'sd0) ? '0 : r[SCORE_W-1:0];
        return s;
    endfunction

    function automatic score_t score_co2(input logic [15:0] c);
        calc_t x;
        calc_t r;
        x = signed'(CALC_W'(c));
        priority if (x <= 21'sd600)  r = 21'sd10000;
        else if (x <= 21'sd800)  r = 21'sd10000 - (x - 21'sd600) * 21'sd10;
        else if (x <= 21'sd1000) r = 21'sd8000 - (x - 21'sd800) * 21'sd10;
        else if (x <= 21'sd1500) r = 21'sd6000 - (x - 21'sd1000) * 21'sd6;
        else if (x <= 21'sd2000) r = 21'sd3000 - (x - 21'sd1500) * 21'sd4;
        else                     r = 21'sd1000 - (x - 21'sd2000);
        return clamp_score(r);
    endfunction

    function automatic score_t score_temp(input logic signed [14:0] t);
        calc_t x;
        calc_t r;
        x = signed'(CALC_W'(t));
        priority if (x >= 21'sd2000 && x <= 21'sd2400) r = 21'sd10000;
        else if (x >= 21'sd1800 && x < 21'sd2000)
            r = 21'sd7000 + (x - 21'sd1800) * 21'sd15;
        else if (x > 21'sd2400 && x <= 21'sd2600)
            r = 21'sd10000 - (x - 21'sd2400) * 21'sd15;
        else if (x >= 21'sd1600 && x < 21'sd1800)
            r = 21'sd3000 + (x - 21'sd1600) * 21'sd20;
        else if (x > 21'sd2600 && x <= 21'sd2800)
            r = 21'sd7000 - (x - 21'sd2600) * 21'sd20;
        else if (x < 21'sd1600)
            r = 21'sd3000 - (21'sd1600 - x) * 21'sd10;
        else
            r = 21'sd3000 - (x - 21'sd2800) * 21'sd10;
        return clamp_score(r);
    endfunction

    function automatic score_t score_hum(input logic [13:0] h);
        calc_t x;
        calc_t r;
        x = signed'(CALC_W'(h));
        priority if (x >= 21'sd4000 && x <= 21'sd6000) r = 21'sd10000;
        else if (x >= 21'sd3000 && x < 21'sd4000)
            r = 21'sd6000 + (x - 21'sd3000) * 21'sd4;
        else if (x > 21'sd6000 && x <= 21'sd7000)
            r = 21'sd10000 - (x - 21'sd6000) * 21'sd4;
        else if (x >= 21'sd2000 && x < 21'sd3000)
            r = 21'sd2000 + (x - 21'sd2000) * 21'sd4;
        else if (x > 21'sd7000 && x <= 21'sd8000)
            r = 21'sd6000 - (x - 21'sd7000) * 21'sd4;
        else if (x < 21'sd2000)
            r = 21'sd2000 - (21'sd2000 - x) * 21'sd2;
        else
            r = 21'sd2000 - (x - 21'sd8000) * 21'sd2;
        return clamp_score(r);
    endfunction

endpackage

`default_nettype wire

/* src/acis_score_stage.sv */
// Stage 1: piecewise-linear sub-scores of one reading, registered.
// Depends on acis_pkg.
`default_nettype none

module acis_score_stage (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    in_valid,
    output logic                         in_ready,
    input  wire logic [15:0]             co2_ppm,
    input  wire logic signed [14:0]      temp_centi,
    input  wire logic [13:0]             hum_centi,
    output logic                         out_valid,
    input  wire logic                    out_ready,
    output acis_pkg::score_set_t         scores
);
    import acis_pkg::*;

    logic       valid_reg;
    logic       valid_next;
    score_set_t scores_reg;
    score_set_t scores_next;

    assign in_ready = !valid_reg || out_ready;
    assign valid_next = in_ready ? in_valid : valid_reg;

    always_comb
    begin
        scores_next.co2  = score_co2(co2_ppm);
        scores_next.temp = score_temp(temp_centi);
        scores_next.hum  = score_hum(hum_centi);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
            scores_reg <= scores_next;
    end

    assign out_valid = valid_reg;
    assign scores    = scores_reg;

endmodule

`default_nettype wire

/* src/acis_weight_stage.sv */
// Stage 2: sub-score times weight products; sub-scores travel alongside.
// Depends on acis_pkg.
`default_nettype none

module acis_weight_stage (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    in_valid,
    output logic                         in_ready,
    input  wire acis_pkg::score_set_t    in_scores,
    input  wire acis_pkg::weight_set_t   weights,
    output logic                         out_valid,
    input  wire logic                    out_ready,
    output acis_pkg::score_set_t         out_scores,
    output acis_pkg::prod_set_t          prods
);
    import acis_pkg::*;

    logic       valid_reg;
    logic       valid_next;
    score_set_t scores_reg;
    prod_set_t  prods_reg;
    prod_set_t  prods_next;

    assign in_ready = !valid_reg || out_ready;
    assign valid_next = in_ready ? in_valid : valid_reg;

    always_comb
    begin
        prods_next.co2  = PROD_W'(in_scores.co2)  * PROD_W'(weights.co2);
        prods_next.temp = PROD_W'(in_scores.temp) * PROD_W'(weights.temp);
        prods_next.hum  = PROD_W'(in_scores.hum)  * PROD_W'(weights.hum);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            scores_reg <= in_scores;
            prods_reg  <= prods_next;
        end
    end

    assign out_valid  = valid_reg;
    assign out_scores = scores_reg;
    assign prods      = prods_reg;

endmodule

`default_nettype wire

/* src/acis_sum_stage.sv */
// Stage 3: composite sum and label class; this is the output register.
// Depends on acis_pkg.
`default_nettype none

module acis_sum_stage (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    in_valid,
    output logic                         in_ready,
    input  wire acis_pkg::score_set_t    in_scores,
    input  wire acis_pkg::prod_set_t     prods,
    output logic                         out_valid,
    input  wire logic                    out_ready,
    output acis_pkg::score_set_t         out_scores,
    output acis_pkg::comp_t              composite,
    output acis_pkg::label_t             label
);
    import acis_pkg::*;

    logic       valid_reg;
    logic       valid_next;
    score_set_t scores_reg;
    comp_t      comp_reg;
    comp_t      comp_next;
    label_t     label_reg;
    label_t     label_next;

    assign in_ready = !valid_reg || out_ready;
    assign valid_next = in_ready ? in_valid : valid_reg;

    always_comb
    begin
        comp_next = COMP_W'(prods.co2) + COMP_W'(prods.temp) + COMP_W'(prods.hum);
        priority if (comp_next >= THR_EXCELLENT) label_next = LABEL_EXCELLENT;
        else if (comp_next >= THR_GOOD)          label_next = LABEL_GOOD;
        else if (comp_next >= THR_AVERAGE)       label_next = LABEL_AVERAGE;
        else if (comp_next >= THR_POOR)          label_next = LABEL_POOR;
        else                                     label_next = LABEL_CRITICAL;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            scores_reg <= in_scores;
            comp_reg   <= comp_next;
            label_reg  <= label_next;
        end
    end

    assign out_valid  = valid_reg;
    assign out_scores = scores_reg;
    assign composite  = comp_reg;
    assign label      = label_reg;

endmodule

`default_nettype wire

/* src/air_comfort_index_score_unit.sv */
// Three register stages (sub-scores, weight products, composite sum and label),
// in that order, each hold one beat and advance independently; one reading per
// cycle is taken while the output is not stalled.
// A stalled output backs up stage by stage; no beat is dropped or repeated.
// Reset (rst_n low, asynchronous): pipeline empties, weights return to 40/35/25.
`default_nettype none
`include "air_comfort_index_score_unit_defines.svh"

// Top level: weight registers, configuration port and the three-stage pipeline.
// Depends on acis_pkg, acis_score_stage, acis_weight_stage, acis_sum_stage.
module air_comfort_index_score_unit (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    // configuration write channel
    input  wire logic                    cfg_valid,
    output logic                         cfg_ready,
    input  wire acis_pkg::reg_idx_t      cfg_index,
    input  wire acis_pkg::weight_t       cfg_data,
    // reading channel
    input  wire logic                    in_valid,
    output logic                         in_ready,
    input  wire logic [15:0]             co2_ppm,
    input  wire logic signed [14:0]      temp_centi,
    input  wire logic [13:0]             hum_centi,
    // result channel
    output logic                         out_valid,
    input  wire logic                    out_ready,
    output acis_pkg::score_t             co2_score,
    output acis_pkg::score_t             temp_score,
    output acis_pkg::score_t             hum_score,
    output acis_pkg::comp_t              composite_score,
    output acis_pkg::label_t             label_class
);
    import acis_pkg::*;

    // Weight registers. Writes are only expected while the pipe is empty,
    // so stage 2 reads them directly without a shadow copy.
    weight_set_t weights_reg;
    weight_set_t weights_next;

    // Inter-stage handshake and payload
    logic        s1_valid;
    logic        s1_ready;
    score_set_t  s1_scores;
    logic        s2_valid;
    logic        s2_ready;
    score_set_t  s2_scores;
    prod_set_t   s2_prods;
    score_set_t  s3_scores;

    // Configuration port never stalls; an index past the list is dropped.
    assign cfg_ready = 1'b1;

    always_comb
    begin
        weights_next = weights_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_CO2_WEIGHT:  weights_next.co2  = cfg_data;
                REG_TEMP_WEIGHT: weights_next.temp = cfg_data;
                REG_HUM_WEIGHT:  weights_next.hum  = cfg_data;
                default:         weights_next      = weights_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            weights_reg.co2  <= CO2_WEIGHT_RST;
            weights_reg.temp <= TEMP_WEIGHT_RST;
            weights_reg.hum  <= HUM_WEIGHT_RST;
        end
        else
        begin
            weights_reg <= weights_next;
        end
    end

    // Stage 1: sub-scores
    acis_score_stage u_score (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .co2_ppm    (co2_ppm),
        .temp_centi (temp_centi),
        .hum_centi  (hum_centi),
        .out_valid  (s1_valid),
        .out_ready  (s1_ready),
        .scores     (s1_scores)
    );

    // Stage 2: weight products
    acis_weight_stage u_weight (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s1_valid),
        .in_ready   (s1_ready),
        .in_scores  (s1_scores),
        .weights    (weights_reg),
        .out_valid  (s2_valid),
        .out_ready  (s2_ready),
        .out_scores (s2_scores),
        .prods      (s2_prods)
    );

    // Stage 3: composite and label, doubles as the output register
    acis_sum_stage u_sum (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s2_valid),
        .in_ready   (s2_ready),
        .in_scores  (s2_scores),
        .prods      (s2_prods),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_scores (s3_scores),
        .composite  (composite_score),
        .label      (label_class)
    );

    assign co2_score  = s3_scores.co2;
    assign temp_score = s3_scores.temp;
    assign hum_score  = s3_scores.hum;

    // The input side may only stall when a result is waiting at the output.
    `ACIS_ASSERT_IMPL(a_stall_needs_out, !in_ready, out_valid,
        "input stalled while output stage is empty")
    // Sub-scores stay within the full-point range.
    `ACIS_ASSERT_IMPL(a_score_range, out_valid,
        co2_score <= SCORE_MAX && temp_score <= SCORE_MAX && hum_score <= SCORE_MAX,
        "sub-score above full scale")
    // Label must agree with the composite it travels with.
    `ACIS_ASSERT_IMPL(a_label_excellent, out_valid,
        (label_class == LABEL_EXCELLENT) == (composite_score >= THR_EXCELLENT),
        "excellent label does not match composite")
    `ACIS_ASSERT_IMPL(a_label_critical, out_valid,
        (label_class == LABEL_CRITICAL) == (composite_score < THR_POOR),
        "critical label does not match composite")
    // A valid result carries one of the five label classes.
    `ACIS_ASSERT_NEVER(a_label_code, out_valid && label_class > LABEL_CRITICAL,
        "label code out of range")

endmodule

`default_nettype wire
